### rtl/utf8_control_char_escaper_defines.svh
// Assertion macros for the escaper RTL, included by u8esc_emit.sv.
`ifndef UTF8_CONTROL_CHAR_ESCAPER_DEFINES_SVH
`define UTF8_CONTROL_CHAR_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on an explicit clock and active-low reset.
`define U8ESC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the module's i_clk and i_rst_n.
`define U8ESC_ASSERT(lbl, prop, msg) \
    `U8ESC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define U8ESC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define U8ESC_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/u8esc_pkg.sv
// Shared types, constants and helper functions of the UTF-8 control escaper.
`default_nettype none

package u8esc_pkg;

    localparam int RUN_MAX   = 6;
    localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // One burst of output bytes produced by a finished sequence
    typedef struct packed {
        logic [RUN_CNT_W-1:0]    count;
        logic [RUN_MAX-1:0][7:0] bytes;
    } t_run;

    function automatic logic is_control(input logic [20:0] cp);
        return (cp <= 21'h00001f) ||
               (cp >= 21'h00007f && cp <= 21'h00009f) ||
               (cp == 21'h00061c) ||
               (cp >= 21'h00200b && cp <= 21'h00200f) ||
               (cp >= 21'h002028 && cp <= 21'h00202e) ||
               (cp >= 21'h002060 && cp <= 21'h00206f) ||
               (cp == 21'h00feff);
    endfunction

    // Lowercase hex digit in ASCII
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});
    endfunction

endpackage

`default_nettype wire

### rtl/u8esc_decode.sv
// Sequence decoder: gathers code points and builds the output burst per sequence.
`default_nettype none

module u8esc_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_byte,
    output u8esc_pkg::t_run     o_run,
    output logic                o_run_valid
);

    logic [20:0]     r_cp, n_cp;
    logic [1:0]      r_rem, n_rem;
    logic [1:0]      r_hc, n_hc;
    logic [2:0][7:0] r_held, n_held;

    logic        done;
    logic [20:0] cp_fin;
    logic [1:0]  hc_fin;

    always_comb begin
        n_cp   = r_cp;
        n_rem  = r_rem;
        n_hc   = r_hc;
        n_held = r_held;
        done   = 1'b0;
        cp_fin = r_cp;
        hc_fin = 2'd0;
        if (r_rem == 2'd0) begin
            if (!i_byte[7]) begin
                done   = 1'b1;
                cp_fin = {13'b0, i_byte};
            end else begin
                priority if (i_byte < 8'he0) begin
                    n_cp  = {16'b0, i_byte[4:0]};
                    n_rem = 2'd1;
                end else if (i_byte < 8'hf0) begin
                    n_cp  = {17'b0, i_byte[3:0]};
                    n_rem = 2'd2;
                end else begin
                    n_cp  = {18'b0, i_byte[2:0]};
                    n_rem = 2'd3;
                end
                n_held[0] = i_byte;
                n_hc      = 2'd1;
            end
        end else begin
            // any byte inside an open sequence counts as a continuation
            cp_fin = {r_cp[14:0], i_byte[5:0]};
            n_rem  = r_rem - 2'd1;
            if (r_rem == 2'd1) begin
                done   = 1'b1;
                hc_fin = r_hc;
            end else begin
                n_cp = cp_fin;
                if (r_hc != 2'd3) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_hc == 2'(i)) n_held[i] = i_byte;
                    end
                    n_hc = r_hc + 2'd1;
                end
            end
        end
        if (done) begin
            n_cp  = '0;
            n_rem = 2'd0;
            n_hc  = 2'd0;
        end
    end

    // Build the burst: escape for controls, raw bytes otherwise
    always_comb begin
        o_run       = '0;
        o_run_valid = i_accept && done;
        if (u8esc_pkg::is_control(cp_fin)) begin
            o_run.bytes[0] = u8esc_pkg::CH_BACKSLASH;
            if (cp_fin <= 21'h0000ff) begin
                o_run.count    = u8esc_pkg::RUN_CNT_W'(4);
                o_run.bytes[1] = u8esc_pkg::CH_LOWER_X;
                o_run.bytes[2] = u8esc_pkg::hex_char(cp_fin[7:4]);
                o_run.bytes[3] = u8esc_pkg::hex_char(cp_fin[3:0]);
            end else begin
                o_run.count    = u8esc_pkg::RUN_CNT_W'(6);
                o_run.bytes[1] = u8esc_pkg::CH_LOWER_U;
                o_run.bytes[2] = u8esc_pkg::hex_char(cp_fin[15:12]);
                o_run.bytes[3] = u8esc_pkg::hex_char(cp_fin[11:8]);
                o_run.bytes[4] = u8esc_pkg::hex_char(cp_fin[7:4]);
                o_run.bytes[5] = u8esc_pkg::hex_char(cp_fin[3:0]);
            end
        end else begin
            o_run.count = u8esc_pkg::RUN_CNT_W'({1'b0, hc_fin}) + u8esc_pkg::RUN_CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < hc_fin) o_run.bytes[i] = r_held[i];
            end
            for (int i = 0; i < 4; i++) begin
                if (2'(i) == hc_fin) o_run.bytes[i] = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp  <= '0;
            r_rem <= 2'd0;
            r_hc  <= 2'd0;
        end else if (i_accept) begin
            r_cp  <= n_cp;
            r_rem <= n_rem;
            r_hc  <= n_hc;
        end
    end

    // held bytes are only read below the held count, so no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

### rtl/u8esc_emit.sv
// Output burst register: drains one byte per transaction and marks the last.
`default_nettype none

`include "utf8_control_char_escaper_defines.svh"

module u8esc_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire u8esc_pkg::t_run i_run,
    output logic                o_free,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic [u8esc_pkg::RUN_CNT_W-1:0]             r_cnt, n_cnt;
    logic [u8esc_pkg::RUN_MAX-1:0][7:0]          r_bytes, n_bytes;
    logic                                        take;

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == u8esc_pkg::RUN_CNT_W'(1));
    assign o_byte  = r_bytes[0];
    assign take    = o_valid && i_ready;
    // free when empty or when the final byte of the burst leaves this cycle
    assign o_free  = !o_valid || (take && o_last);

    always_comb begin
        n_cnt   = r_cnt;
        n_bytes = r_bytes;
        if (i_load) begin
            n_cnt   = i_run.count;
            n_bytes = i_run.bytes;
        end else if (take) begin
            n_cnt   = r_cnt - u8esc_pkg::RUN_CNT_W'(1);
            n_bytes = r_bytes >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    `U8ESC_ASSERT(a_load_gives_valid, i_load |=> o_valid, "loaded burst not presented")
    `U8ESC_ASSERT(a_stall_blocks_input, (o_valid && !i_ready) |-> !o_free, "free while stalled")
    `U8ESC_ASSERT(a_last_empties, (take && o_last && !i_load) |=> !o_valid, "burst not drained")

endmodule

`default_nettype wire

### rtl/utf8_control_char_escaper.sv
// Top level of the UTF-8 terminal-control escaper.
//
// Slave channel (i_s_*): one UTF-8 byte per transaction in tdata.
// Master channel (o_m_*): one output character byte per transaction in tdata;
// tlast marks the final byte caused by one input byte.
// Each input byte is decoded as it is accepted. Lead and middle bytes of a
// multi-byte sequence produce nothing; the final byte produces a burst: the
// original 1 to 4 bytes, or a lowercase escape of 4 (\xHH) or 6 (\uHHHH) bytes
// when the code point is a terminal control (C0, DEL/C1, U+061C, U+200B-200F,
// U+2028-202E, U+2060-206F, U+FEFF).
// The first output byte appears in the cycle after the input transaction.
// Throughput: one input byte per cycle while bursts are single bytes and the
// receiver is ready; a longer burst holds the input while the one-byte output
// register drains it. A new byte is taken in the cycle the last burst byte leaves.
// Reset (synchronous, active low) drops any open sequence and queued burst.
// A stalled receiver holds the current byte and blocks the input channel.
`default_nettype none

module utf8_control_char_escaper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast
);

    logic            accept;
    logic            run_valid;
    u8esc_pkg::t_run run;

    // accept only when the burst register can take whatever this byte yields
    assign accept = i_s_tvalid && o_s_tready;

    u8esc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_run       (run),
        .o_run_valid (run_valid)
    );

    u8esc_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (run_valid),
        .i_run   (run),
        .o_free  (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

`default_nettype wire
